// File: rtl/core/llc_pkg.sv
// shared types, constants and helpers for the luhn check and issuer class block
// no dependencies; every stage module and the top in rtl/core import this package
`default_nettype none

package llc_pkg;

	// payload widths
	localparam int CARD_W     = 63;
	localparam int BCD_DIGITS = 19;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int COUNT_W    = 5;
	localparam int CLASS_W    = 2;

	// conversion pipeline: a fixed number of binary bits folded in per stage
	localparam int BITS_PER_STAGE = 8;
	localparam int CONV_STAGES    = (CARD_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
	localparam int LAST_BITS      = CARD_W - BITS_PER_STAGE * (CONV_STAGES - 1);

	// luhn sum is split in groups of digits, all summed in the digit stage
	localparam int GROUP_N = 5;
	localparam int GROUPS  = (BCD_DIGITS + GROUP_N - 1) / GROUP_N;
	localparam int GSUM_W  = 6;
	localparam int SUM_W   = 8;
	localparam int SUM_MAX = 9 * BCD_DIGITS;

	// default digit limit
	localparam int MAX_DIGITS_DEF = 19;

	// issuer class codes
	localparam logic [CLASS_W-1:0] CLS_INVALID   = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_PREFIX_3X = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_PREFIX_4  = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_PREFIX_5X = 2'd3;

	// lengths that the class rules look at
	localparam logic [COUNT_W-1:0] LEN_13 = 5'd13;
	localparam logic [COUNT_W-1:0] LEN_15 = 5'd15;
	localparam logic [COUNT_W-1:0] LEN_16 = 5'd16;

	typedef struct packed {
		logic [CARD_W-1:0] card_number;
	} card_t;

	typedef struct packed {
		logic [CLASS_W-1:0] issuer_class;
		logic               checksum_ok;
		logic [COUNT_W-1:0] digit_count;
	} result_t;

	// binary-to-bcd shift state
	typedef struct packed {
		logic [CARD_W-1:0] bin;
		logic [BCD_W-1:0]  bcd;
	} conv_t;

	// after digit mapping: group sums, length and the digits the prefix rules need
	typedef struct packed {
		logic [GROUPS-1:0][GSUM_W-1:0] gsum;
		logic [COUNT_W-1:0]            count;
		logic                          over;
		logic [3:0]                    d12;
		logic [3:0]                    d13;
		logic [3:0]                    d14;
		logic [3:0]                    d15;
	} dig_t;

	// after the sum: check result, length and prefix digits
	typedef struct packed {
		logic               ok;
		logic [COUNT_W-1:0] count;
		logic [3:0]         d12;
		logic [3:0]         d13;
		logic [3:0]         d14;
		logic [3:0]         d15;
	} sum_t;

	// doubled digit reduced to its digit sum
	function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
		logic [4:0] t;
		t = {d, 1'b0};
		if (t >= 5'd10)
			t = t - 5'd9;
		return t[3:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/llc_stream_if.sv
// valid/ready stream channel with a typed payload
// no dependencies
`default_nettype none

interface llc_stream_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: rtl/core/llc_bcd_stage.sv
// one stage of the binary-to-bcd converter (shift and add-3 over NBITS bits)
// depends on llc_pkg
`default_nettype none

module llc_bcd_stage #(
	parameter int NBITS = llc_pkg::BITS_PER_STAGE
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld,
	input  llc_pkg::conv_t conv,
	output logic           vld_s1,
	output llc_pkg::conv_t conv_s1
);
	import llc_pkg::*;

	conv_t nxt;

	// fold NBITS binary bits into the bcd digits, msb first
	always_comb begin
		conv_t w;
		w = conv;
		for (int b = 0; b < NBITS; b++) begin
			for (int d = 0; d < BCD_DIGITS; d++) begin
				if (w.bcd[d*4 +: 4] >= 4'd5)
					w.bcd[d*4 +: 4] = w.bcd[d*4 +: 4] + 4'd3;
			end
			w.bcd = {w.bcd[BCD_W-2:0], w.bin[CARD_W-1]};
			w.bin = {w.bin[CARD_W-2:0], 1'b0};
		end
		nxt = w;
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= vld;
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en)
			conv_s1 <= nxt;
	end

endmodule

`default_nettype wire

// File: rtl/core/llc_digit_stage.sv
// digit stage: length, luhn weighting and partial sums per digit group
// depends on llc_pkg
`default_nettype none

module llc_digit_stage #(
	parameter int MAX_DIGITS = llc_pkg::MAX_DIGITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vld,
	input  logic [llc_pkg::BCD_W-1:0] bcd,
	output logic                      vld_s9,
	output llc_pkg::dig_t             dig_s9
);
	import llc_pkg::*;

	localparam logic [COUNT_W-1:0] MAXD = COUNT_W'(MAX_DIGITS);

	dig_t nxt;

	always_comb begin
		logic [3:0]         d;
		logic [3:0]         v;
		logic [COUNT_W-1:0] cnt;
		nxt = '0;
		cnt = '0;
		// length is the position of the highest nonzero digit
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd[i*4 +: 4] != 4'd0)
				cnt = COUNT_W'(i + 1);
		end
		// weighted digits summed per group, every second digit doubled
		for (int g = 0; g < GROUPS; g++) begin
			for (int k = 0; k < GROUP_N; k++) begin
				if (g * GROUP_N + k < BCD_DIGITS) begin
					d = bcd[(g*GROUP_N + k)*4 +: 4];
					v = (((g * GROUP_N + k) % 2) == 1) ? luhn_dbl(d) : d;
					nxt.gsum[g] = nxt.gsum[g] + GSUM_W'(v);
				end
			end
		end
		// too long: reject and report the limit as the length
		nxt.over  = (cnt > MAXD);
		nxt.count = nxt.over ? MAXD : cnt;
		nxt.d12   = bcd[12*4 +: 4];
		nxt.d13   = bcd[13*4 +: 4];
		nxt.d14   = bcd[14*4 +: 4];
		nxt.d15   = bcd[15*4 +: 4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s9 <= 1'b0;
		else if (en)
			vld_s9 <= vld;
	end

	always_ff @(posedge clk) begin
		if (en)
			dig_s9 <= nxt;
	end

endmodule

`default_nettype wire

// File: rtl/core/llc_sum_stage.sv
// sum stage: adds the group sums and checks the total against multiples of ten
// depends on llc_pkg
`default_nettype none

module llc_sum_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld,
	input  llc_pkg::dig_t dig,
	output logic          vld_s10,
	output llc_pkg::sum_t sum_s10
);
	import llc_pkg::*;

	sum_t nxt;

	always_comb begin
		logic [SUM_W-1:0] total;
		logic             mult10;
		total  = '0;
		mult10 = 1'b0;
		// total of the groups
		for (int g = 0; g < GROUPS; g++)
			total = total + SUM_W'(dig.gsum[g]);
		// multiple of ten by compare against each candidate
		for (int k = 0; k <= SUM_MAX / 10; k++) begin
			if (total == SUM_W'(10 * k))
				mult10 = 1'b1;
		end
		nxt.ok    = mult10 && !dig.over;
		nxt.count = dig.count;
		nxt.d12   = dig.d12;
		nxt.d13   = dig.d13;
		nxt.d14   = dig.d14;
		nxt.d15   = dig.d15;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s10 <= 1'b0;
		else if (en)
			vld_s10 <= vld;
	end

	always_ff @(posedge clk) begin
		if (en)
			sum_s10 <= nxt;
	end

endmodule

`default_nettype wire

// File: rtl/core/llc_class_stage.sv
// output stage: issuer class from length and leading digits, result register
// depends on llc_pkg
`default_nettype none

module llc_class_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld,
	input  llc_pkg::sum_t    sums,
	output logic             vld_s11,
	output llc_pkg::result_t res_s11
);
	import llc_pkg::*;

	result_t nxt;

	// class rules in priority order
	always_comb begin
		nxt.checksum_ok = sums.ok;
		nxt.digit_count = sums.count;
		priority if (!sums.ok)
			nxt.issuer_class = CLS_INVALID;
		else if (sums.count == LEN_15 && sums.d14 == 4'd3
				&& (sums.d13 == 4'd4 || sums.d13 == 4'd7))
			nxt.issuer_class = CLS_PREFIX_3X;
		else if ((sums.count == LEN_13 && sums.d12 == 4'd4)
				|| (sums.count == LEN_16 && sums.d15 == 4'd4))
			nxt.issuer_class = CLS_PREFIX_4;
		else if (sums.count == LEN_16 && sums.d15 == 4'd5
				&& sums.d14 >= 4'd1 && sums.d14 <= 4'd5)
			nxt.issuer_class = CLS_PREFIX_5X;
		else
			nxt.issuer_class = CLS_INVALID;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s11 <= 1'b0;
		else if (en)
			vld_s11 <= vld;
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s11 <= nxt;
	end

endmodule

`default_nettype wire

// File: rtl/core/luhn_check_and_issuer_class.sv
// pipeline depth: 11 register stages
// throughput: one card number per cycle while no result is stalled; the 63-bit binary-to-bcd conversion
//   takes 8 stages (8 bits each, 7 in the last), then digit, sum and class stages
// a stalled result freezes the whole pipeline; no beat is lost or repeated
// reset (arst_n low) clears all stage valid bits; payload registers keep data
// depends on llc_pkg, llc_stream_if and the llc stage modules
`default_nettype none

module luhn_check_and_issuer_class #(
	parameter int MAX_DIGITS = llc_pkg::MAX_DIGITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	llc_stream_if.sink    card,
	llc_stream_if.source  result
);
	import llc_pkg::*;

	logic    en;
	logic    vld    [CONV_STAGES+1];
	conv_t   conv   [CONV_STAGES+1];
	logic    vld_dig;
	dig_t    dig;
	logic    vld_sum;
	sum_t    sums;
	logic    vld_res;
	result_t res;

	// whole pipeline advances unless a finished result is held
	assign en         = !vld_res || result.ready;
	assign card.ready = en;

	// conversion input
	assign vld[0]      = card.valid;
	assign conv[0].bin = card.data.card_number;
	assign conv[0].bcd = '0;

	// binary-to-bcd stages
	for (genvar s = 0; s < CONV_STAGES; s++) begin : g_conv
		localparam int NB = (s == CONV_STAGES - 1) ? LAST_BITS : BITS_PER_STAGE;
		llc_bcd_stage #(
			.NBITS (NB)
		) u_bcd (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld     (vld[s]),
			.conv    (conv[s]),
			.vld_s1  (vld[s+1]),
			.conv_s1 (conv[s+1])
		);
	end

	llc_digit_stage #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (vld[CONV_STAGES]),
		.bcd    (conv[CONV_STAGES].bcd),
		.vld_s9 (vld_dig),
		.dig_s9 (dig)
	);

	llc_sum_stage u_sum (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (vld_dig),
		.dig     (dig),
		.vld_s10 (vld_sum),
		.sum_s10 (sums)
	);

	llc_class_stage u_class (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (vld_sum),
		.sums    (sums),
		.vld_s11 (vld_res),
		.res_s11 (res)
	);

	assign result.valid = vld_res;
	assign result.data  = res;

	// a class is only given to a number that passed the check
	a_class_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.issuer_class != CLS_INVALID
			|-> result.data.checksum_ok)
		else $error("issuer class set without passing checksum");

	// a class only goes with one of the lengths the rules name
	a_class_length: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.issuer_class != CLS_INVALID
			|-> (result.data.digit_count == LEN_13
				|| result.data.digit_count == LEN_15
				|| result.data.digit_count == LEN_16))
		else $error("issuer class with a length no rule allows");

	// reported length never exceeds the digit limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.data.digit_count <= COUNT_W'(MAX_DIGITS))
		else $error("digit count above the limit");

	// a held result blocks new beats on the input
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !card.ready)
		else $error("input accepted while the pipeline is stalled");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// self-checking bench for luhn_check_and_issuer_class: random and directed card numbers,
// each result checked field by field against a predictor of the digit walk
// depends on llc_pkg, llc_stream_if and the block itself
`timescale 1ns / 1ps

module testbench;

	import llc_pkg::*;

	localparam int MAX_DIGITS  = MAX_DIGITS_DEF;
	localparam int RAND_CARDS  = 450;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 30;

	typedef struct {
		logic [CARD_W-1:0] card;
		bit                drain;
	} send_t;

	logic clk = 1'b0;
	logic arst_n;

	llc_stream_if #(.T(card_t))   card_in ();
	llc_stream_if #(.T(result_t)) result_out ();

	luhn_check_and_issuer_class #(
		.MAX_DIGITS(MAX_DIGITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.card   (card_in),
		.result (result_out)
	);

	always #4 clk = ~clk;

	send_t   cards_to_send[$];
	result_t verdicts_due[$];

	int errors    = 0;
	int beats_in  = 0;
	int beats_out = 0;
	int bad_sums  = 0;
	int class_seen[4];
	int send_idle = 0;
	int send_calm = 0;
	int recv_hold = 0;
	int recv_calm = 0;
	int quiet     = 0;

	// expected result of one card number: digit count, luhn sum, class rules
	function automatic result_t card_verdict(input logic [CARD_W-1:0] num);
		logic [CARD_W-1:0] rest;
		int count, sum, top, second, d, t, lead;
		result_t r;
		rest = num;
		count = 0;
		sum = 0;
		top = 0;
		second = 0;
		while (rest != 0 && count < MAX_DIGITS) begin
			d = int'(rest % 10);
			rest = rest / 10;
			count++;
			if (count % 2 == 1) begin
				sum += d;
			end else begin
				t = 2 * d;
				if (t >= 10)
					t -= 9;
				sum += t;
			end
			second = top;
			top = d;
		end
		r.issuer_class = CLS_INVALID;
		if (rest != 0) begin
			// too many digits for the configured limit
			r.checksum_ok = 1'b0;
			r.digit_count = COUNT_W'(MAX_DIGITS);
			return r;
		end
		r.checksum_ok = (sum % 10 == 0);
		r.digit_count = COUNT_W'(count);
		lead = top * 10 + second;
		if (r.checksum_ok) begin
			if (count == LEN_15 && (lead == 34 || lead == 37))
				r.issuer_class = CLS_PREFIX_3X;
			else if ((count == LEN_13 || count == LEN_16) && top == 4)
				r.issuer_class = CLS_PREFIX_4;
			else if (count == LEN_16 && lead >= 51 && lead <= 55)
				r.issuer_class = CLS_PREFIX_5X;
		end
		return r;
	endfunction

	// card of a given length and prefix, random middle, check digit that passes
	function automatic logic [CARD_W-1:0] make_card(input int len, input int prefix,
			input int plen);
		longint unsigned n;
		n = prefix;
		for (int i = plen; i < len - 1; i++)
			n = n * 10 + $urandom_range(0, 9);
		n = n * 10;
		for (int c = 0; c < 10; c++) begin
			if (card_verdict(CARD_W'(n + c)).checksum_ok)
				return CARD_W'(n + c);
		end
		return CARD_W'(n);
	endfunction

	// move the last digit by one so the luhn sum no longer passes
	function automatic logic [CARD_W-1:0] break_card(input logic [CARD_W-1:0] n);
		if (n % 10 < 9)
			return n + 1;
		return n - 1;
	endfunction

	// idle length: mostly short, a few long, now and then a calm stretch with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(10, 30);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// well-formed card aimed at the class rules, with some near misses
	function automatic logic [CARD_W-1:0] shaped_card();
		int len;
		case ($urandom_range(0, 9))
			0, 1: return make_card(15, ($urandom_range(0, 1) != 0) ? 34 : 37, 2);
			2, 3: return make_card(($urandom_range(0, 1) != 0) ? 13 : 16, 4, 1);
			4, 5: return make_card(16, 51 + $urandom_range(0, 4), 2);
			6: return make_card(($urandom_range(0, 1) != 0) ? 15 : 16,
				($urandom_range(0, 1) != 0) ? 50 : 56, 2);
			7: begin
				if ($urandom_range(0, 1) != 0)
					return make_card(15, 30 + $urandom_range(0, 9), 2);
				return make_card(14 + $urandom_range(0, 3), 4, 1);
			end
			default: begin
				len = $urandom_range(2, 19);
				return make_card(len, $urandom_range(1, 8), 1);
			end
		endcase
	endfunction

	task automatic queue_card(input logic [CARD_W-1:0] card, input bit drain);
		send_t s;
		s.card = card;
		s.drain = drain;
		cards_to_send.push_back(s);
	endtask

	task automatic flag(input string what);
		errors++;
		if (errors <= 10)
			$display("mismatch: %s", what);
	endtask

	// driver: presents queued cards, idles at random between beats
	always @(posedge clk or negedge arst_n) begin
		send_t s;
		if (!arst_n) begin
			card_in.valid <= 1'b0;
			card_in.data <= '0;
			send_idle = 0;
		end else begin
			if (card_in.valid && card_in.ready) begin
				verdicts_due.push_back(card_verdict(card_in.data.card_number));
				beats_in++;
				send_idle = pick_gap(send_calm);
			end
			if (!card_in.valid || card_in.ready) begin
				if (send_idle > 0) begin
					send_idle--;
					card_in.valid <= 1'b0;
				end else if (cards_to_send.size() != 0 &&
						(!cards_to_send[0].drain || verdicts_due.size() == 0)) begin
					s = cards_to_send.pop_front();
					card_in.data <= '{card_number: s.card};
					card_in.valid <= 1'b1;
				end else begin
					card_in.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks every result beat, stalls at random after a beat
	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		if (!arst_n) begin
			result_out.ready <= 1'b0;
			recv_hold = 0;
		end else begin
			if (result_out.valid && result_out.ready) begin
				got = result_out.data;
				beats_out++;
				if (verdicts_due.size() == 0) begin
					flag($sformatf("result with nothing due: class %0d ok %0b digits %0d",
						got.issuer_class, got.checksum_ok, got.digit_count));
				end else begin
					want = verdicts_due.pop_front();
					if (want.issuer_class != got.issuer_class ||
							want.checksum_ok != got.checksum_ok ||
							want.digit_count != got.digit_count)
						flag($sformatf({"beat %0d: expected class %0d ok %0b digits %0d, ",
							"got class %0d ok %0b digits %0d"}, beats_out,
							want.issuer_class, want.checksum_ok, want.digit_count,
							got.issuer_class, got.checksum_ok, got.digit_count));
					class_seen[want.issuer_class]++;
					if (!want.checksum_ok)
						bad_sums++;
				end
				recv_hold = pick_gap(recv_calm);
			end
			if (recv_hold > 0) begin
				recv_hold--;
				result_out.ready <= 1'b0;
			end else begin
				result_out.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((card_in.valid && card_in.ready) || (result_out.valid && result_out.ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout after %0d idle cycles", quiet);
				$display("testbench: errors");
				$finish;
			end
		end
	end

	initial begin
		logic [CARD_W-1:0] c;
		int r;
		card_in.valid = 1'b0;
		card_in.data = '0;
		result_out.ready = 1'b0;
		arst_n = 1'b0;

		// directed: field extremes, each class, near misses, broken checksums
		queue_card('0, 1'b0);
		queue_card({CARD_W{1'b1}}, 1'b0);
		queue_card(1, 1'b0);
		queue_card(9, 1'b0);
		queue_card(10, 1'b0);
		queue_card(18, 1'b0);
		queue_card(CARD_W'(64'd1000000000000000000), 1'b0);
		queue_card(make_card(19, 8, 1), 1'b0);
		queue_card(make_card(15, 34, 2), 1'b0);
		queue_card(make_card(15, 37, 2), 1'b0);
		queue_card(make_card(13, 4, 1), 1'b0);
		queue_card(make_card(16, 4, 1), 1'b0);
		queue_card(make_card(16, 51, 2), 1'b0);
		queue_card(make_card(16, 55, 2), 1'b0);
		queue_card(make_card(16, 50, 2), 1'b0);
		queue_card(make_card(16, 56, 2), 1'b0);
		queue_card(make_card(15, 35, 2), 1'b0);
		queue_card(make_card(14, 4, 1), 1'b0);
		queue_card(break_card(make_card(15, 34, 2)), 1'b0);
		queue_card(break_card(make_card(16, 4, 1)), 1'b0);
		queue_card(break_card(make_card(16, 52, 2)), 1'b0);
		queue_card(break_card(make_card(13, 4, 1)), 1'b0);

		// random: mostly shaped cards, some broken, the rest raw bit patterns
		for (int i = 0; i < RAND_CARDS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				c = shaped_card();
				if ($urandom_range(0, 99) < 15)
					c = break_card(c);
			end else if (r < 85) begin
				c = CARD_W'({$urandom, $urandom});
			end else begin
				c = CARD_W'({$urandom, $urandom}) >> $urandom_range(0, CARD_W - 1);
			end
			queue_card(c, i == 0 || i == RAND_CARDS / 2);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cards_to_send.size() != 0 || card_in.valid)
			@(posedge clk);
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d card numbers, checked %0d results, %0d with a failed checksum",
			beats_in, beats_out, bad_sums);
		$display("by class: invalid %0d, 34/37 %0d, leading 4 %0d, 51-55 %0d",
			class_seen[0], class_seen[1], class_seen[2], class_seen[3]);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("%0d mismatches in total", errors);
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
